// ===== rtl/bfs_traversal_engine_core_macros.svh =====
// Assertion macros shared by the traversal engine RTL.
`ifndef BFS_TRAVERSAL_ENGINE_CORE_MACROS_SVH
`define BFS_TRAVERSAL_ENGINE_CORE_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define BFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define BFS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/bfs_pkg.sv =====
// Types and constants of the breadth-first traversal engine.
package bfs_pkg;

  localparam int NodeW  = 6;
  localparam int OpW    = 2;
  localparam int ErrW   = 2;
  localparam int CountW = 9;

  typedef enum logic [OpW-1:0] {
    OpAddNode = 2'd0,
    OpAddEdge = 2'd1,
    OpRun     = 2'd2,
    OpClear   = 2'd3
  } op_e;

  typedef enum logic [ErrW-1:0] {
    ErrNone     = 2'd0,
    ErrMissing  = 2'd1,
    ErrOverflow = 2'd2
  } error_e;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDeq  = 4'b0010,
    StScan = 4'b0100,
    StEmit = 4'b1000
  } state_e;

endpackage

// ===== rtl/bfs_traversal_engine_core.sv =====
// Breadth-first traversal engine: graph store, frontier queue and scan sequencer.
//
//   channel  dir  payload                                              handshake
//   in       in   op_i, node_a_i, node_b_i                             in_valid_i/in_ready_o
//   out      out  visited_node_o, last_o, error_o, edges_considered_o  out_valid_o/out_ready_i
//
// Add node, add neighbor entry and clear are each handled in the idle state.
// A run, per dequeued node, reads the queue, scans every stored edge entry and then
// gives one result beat, which may wait for the receiver.
// A missing start node gives its single result beat in the cycle after the run beat.
// The input is not ready during a run; a stalled result beat holds the sequencer.
// No clearing pass follows reset; flags reset at once and the memories need no reset.
module bfs_traversal_engine_core
  import bfs_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OpW-1:0]    op_i,
  input  logic [NodeW-1:0]  node_a_i,
  input  logic [NodeW-1:0]  node_b_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NodeW-1:0]  visited_node_o,
  output logic              last_o,
  output logic [ErrW-1:0]   error_o,
  output logic [CountW-1:0] edges_considered_o
);

  // Only node numbers that fit the field can ever be present.
  localparam int NodeDepth = (MAX_NODES < (1 << NodeW)) ? MAX_NODES : (1 << NodeW);
  localparam int NodeAw    = (NodeDepth > 1) ? $clog2(NodeDepth) : 1;
  localparam int QCw       = $clog2(NodeDepth + 1);
  localparam int EdgeAw    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EdgeCw    = $clog2(MAX_EDGES + 1);
  localparam int EdgeW     = 2 * NodeW;

  function automatic logic node_ok(input logic [NodeW-1:0] x);
    return (32'(x) < MAX_NODES);
  endfunction

  state_e                state_q, state_d;
  logic [NodeDepth-1:0]  present_q, present_d;
  logic [NodeDepth-1:0]  disc_q, disc_d;
  logic [EdgeCw-1:0]     edge_cnt_q, edge_cnt_d;
  logic                  ovf_q, ovf_d;
  logic [QCw-1:0]        head_q, head_d;
  logic [QCw-1:0]        tail_q, tail_d;
  logic [EdgeCw-1:0]     scan_q, scan_d;
  logic                  rdv_q, rdv_d;
  logic [CountW-1:0]     insp_q, insp_d;
  error_e                err_q, err_d;
  logic [NodeW-1:0]      onode_q, onode_d;
  logic                  olast_q, olast_d;
  error_e                oerr_q, oerr_d;
  logic [CountW-1:0]     ocnt_q, ocnt_d;

  logic [EdgeW-1:0]      edge_mem [MAX_EDGES];
  logic [EdgeW-1:0]      edge_rd_q;
  logic                  edge_we, edge_re;
  logic [NodeW-1:0]      queue_mem [NodeDepth];
  logic [NodeW-1:0]      q_rd_q;
  logic                  q_we, q_re;
  logic [NodeAw-1:0]     q_waddr;
  logic [NodeW-1:0]      q_wdata;

  logic [NodeW-1:0]      cur;
  logic [NodeW-1:0]      e_src, e_tgt;
  logic                  in_fire;

  assign in_fire = in_valid_i && in_ready_o;
  assign cur     = q_rd_q;
  assign e_src   = edge_rd_q[EdgeW-1:NodeW];
  assign e_tgt   = edge_rd_q[NodeW-1:0];

  always_comb begin
    state_d    = state_q;
    present_d  = present_q;
    disc_d     = disc_q;
    edge_cnt_d = edge_cnt_q;
    ovf_d      = ovf_q;
    head_d     = head_q;
    tail_d     = tail_q;
    scan_d     = scan_q;
    rdv_d      = 1'b0;
    insp_d     = insp_q;
    err_d      = err_q;
    onode_d    = onode_q;
    olast_d    = olast_q;
    oerr_d     = oerr_q;
    ocnt_d     = ocnt_q;
    edge_we    = 1'b0;
    edge_re    = 1'b0;
    q_we       = 1'b0;
    q_re       = 1'b0;
    q_waddr    = tail_q[NodeAw-1:0];
    q_wdata    = e_tgt;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          case (op_e'(op_i))
            OpAddNode: begin
              if (node_ok(node_a_i)) begin
                present_d[node_a_i[NodeAw-1:0]] = 1'b1;
              end
            end
            OpAddEdge: begin
              if (node_ok(node_a_i) && node_ok(node_b_i)) begin
                if (edge_cnt_q == EdgeCw'(MAX_EDGES)) begin
                  ovf_d = 1'b1;
                end else begin
                  edge_we    = 1'b1;
                  edge_cnt_d = edge_cnt_q + 1'b1;
                  present_d[node_a_i[NodeAw-1:0]] = 1'b1;
                  present_d[node_b_i[NodeAw-1:0]] = 1'b1;
                end
              end
            end
            OpRun: begin
              if (!node_ok(node_a_i) || !present_q[node_a_i[NodeAw-1:0]]) begin
                onode_d = '0;
                olast_d = 1'b1;
                oerr_d  = ErrMissing;
                ocnt_d  = '0;
                state_d = StEmit;
              end else begin
                err_d   = ovf_q ? ErrOverflow : ErrNone;
                disc_d  = '0;
                disc_d[node_a_i[NodeAw-1:0]] = 1'b1;
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = node_a_i;
                head_d  = '0;
                tail_d  = QCw'(1);
                insp_d  = '0;
                state_d = StDeq;
              end
            end
            OpClear: begin
              present_d  = '0;
              edge_cnt_d = '0;
              ovf_d      = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      StDeq: begin
        q_re    = 1'b1;
        head_d  = head_q + 1'b1;
        scan_d  = '0;
        state_d = StScan;
      end
      StScan: begin
        // One edge entry is read per cycle; the compare works on last cycle's read.
        if (rdv_q && (e_src == cur)) begin
          insp_d = insp_q + 1'b1;
          if (node_ok(e_tgt) && !disc_q[e_tgt[NodeAw-1:0]]) begin
            disc_d[e_tgt[NodeAw-1:0]] = 1'b1;
            q_we   = 1'b1;
            tail_d = tail_q + 1'b1;
          end
        end
        if (scan_q != edge_cnt_q) begin
          edge_re = 1'b1;
          rdv_d   = 1'b1;
          scan_d  = scan_q + 1'b1;
        end else if (!rdv_q) begin
          onode_d = cur;
          olast_d = (head_q == tail_q);
          oerr_d  = err_q;
          ocnt_d  = (head_q == tail_q) ? insp_q : '0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_ready_i) begin
          state_d = olast_q ? StIdle : StDeq;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      present_q  <= '0;
      disc_q     <= '0;
      edge_cnt_q <= '0;
      ovf_q      <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      scan_q     <= '0;
      rdv_q      <= 1'b0;
      insp_q     <= '0;
      err_q      <= ErrNone;
    end else begin
      state_q    <= state_d;
      present_q  <= present_d;
      disc_q     <= disc_d;
      edge_cnt_q <= edge_cnt_d;
      ovf_q      <= ovf_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      scan_q     <= scan_d;
      rdv_q      <= rdv_d;
      insp_q     <= insp_d;
      err_q      <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    onode_q <= onode_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
    ocnt_q  <= ocnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_cnt_q[EdgeAw-1:0]] <= {node_a_i, node_b_i};
    end
    if (edge_re) begin
      edge_rd_q <= edge_mem[scan_q[EdgeAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_q <= queue_mem[head_q[NodeAw-1:0]];
    end
  end

  assign in_ready_o         = (state_q == StIdle);
  assign out_valid_o        = (state_q == StEmit);
  assign visited_node_o     = onode_q;
  assign last_o             = olast_q;
  assign error_o            = oerr_q;
  assign edges_considered_o = ocnt_q;

`include "bfs_traversal_engine_core_macros.svh"

  `BFS_ASSERT(a_ready_excl_valid, !(in_ready_o && out_valid_o), "ready while a result waits")
  `BFS_ASSERT(a_queue_order,
              (head_q <= tail_q) && (32'(tail_q) <= NodeDepth), "queue pointers broken")
  `BFS_ASSERT(a_edge_bound, 32'(edge_cnt_q) <= MAX_EDGES, "edge count beyond capacity")
  `BFS_ASSERT(a_missing_last,
              !(out_valid_o && (oerr_q == ErrMissing)) ||
              (last_o && (edges_considered_o == '0)),
              "missing start result malformed")
  `BFS_ASSERT_NEXT(a_missing_next,
                   in_fire && (op_i == OpRun) && !node_ok(node_a_i),
                   out_valid_o && (oerr_q == ErrMissing),
                   "out of range start gave no error beat")

endmodule

// ===== sim/bfs_traversal_engine_core_checker.sv =====
// Checker for the traversal engine: models the graph store and compares every result beat.
module bfs_traversal_engine_core_checker
  import bfs_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [OpW-1:0]    op_i,
  input  logic [NodeW-1:0]  node_a_i,
  input  logic [NodeW-1:0]  node_b_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [NodeW-1:0]  visited_node_i,
  input  logic              last_i,
  input  logic [ErrW-1:0]   error_i,
  input  logic [CountW-1:0] edges_considered_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NodeW-1:0]  node;
    logic              last;
    error_e            err;
    logic [CountW-1:0] count;
  } visit_t;

  logic [MAX_NODES-1:0] node_known = '0;
  logic [NodeW-1:0]     edge_src [MAX_EDGES];
  logic [NodeW-1:0]     edge_dst [MAX_EDGES];
  int                   n_edges = 0;
  logic                 store_overflowed = 1'b0;

  visit_t expected_visits [$];
  int     n_fail = 0;
  int     n_pending = 0;

  assign fail_count_o = n_fail;
  assign pending_o    = n_pending;

  task automatic report_mismatch(input string msg);
    n_fail++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Breadth-first walk over the modeled store; queues one beat per dequeued node.
  task automatic predict_traversal(input logic [NodeW-1:0] start);
    logic [MAX_NODES-1:0] seen;
    logic [NodeW-1:0]     frontier [MAX_NODES];
    logic [NodeW-1:0]     cur;
    int                   head;
    int                   tail;
    int                   inspected;
    error_e               err;
    visit_t               v;
    if (int'(start) >= MAX_NODES || !node_known[start]) begin
      v.node  = '0;
      v.last  = 1'b1;
      v.err   = ErrMissing;
      v.count = '0;
      expected_visits.insert(expected_visits.size(), v);
      return;
    end
    err = store_overflowed ? ErrOverflow : ErrNone;
    seen = '0;
    seen[start] = 1'b1;
    frontier[0] = start;
    head = 0;
    tail = 1;
    inspected = 0;
    while (head < tail) begin
      cur = frontier[head];
      head++;
      for (int e = 0; e < n_edges; e++) begin
        if (edge_src[e] == cur) begin
          inspected++;
          if (int'(edge_dst[e]) < MAX_NODES && !seen[edge_dst[e]] && tail < MAX_NODES) begin
            seen[edge_dst[e]] = 1'b1;
            frontier[tail] = edge_dst[e];
            tail++;
          end
        end
      end
      v.node  = cur;
      v.last  = (head == tail);
      v.err   = err;
      v.count = (head == tail) ? CountW'(inspected) : '0;
      expected_visits.insert(expected_visits.size(), v);
    end
  endtask

  task automatic predict_item(input op_e op, input logic [NodeW-1:0] a,
                              input logic [NodeW-1:0] b);
    case (op)
      OpAddNode: begin
        if (int'(a) < MAX_NODES) node_known[a] = 1'b1;
      end
      OpAddEdge: begin
        if (int'(a) < MAX_NODES && int'(b) < MAX_NODES) begin
          if (n_edges >= MAX_EDGES) begin
            store_overflowed = 1'b1;
          end else begin
            edge_src[n_edges] = a;
            edge_dst[n_edges] = b;
            n_edges++;
            node_known[a] = 1'b1;
            node_known[b] = 1'b1;
          end
        end
      end
      OpRun: begin
        predict_traversal(a);
      end
      default: begin
        node_known = '0;
        n_edges = 0;
        store_overflowed = 1'b0;
      end
    endcase
  endtask

  task automatic check_visit();
    visit_t want;
    if (expected_visits.size() == 0) begin
      report_mismatch($sformatf("unexpected result beat node %0d last %0b error %0d count %0d",
                                visited_node_i, last_i, error_i, edges_considered_i));
      return;
    end
    want = expected_visits.pop_front();
    if (visited_node_i !== want.node)
      report_mismatch($sformatf("visited_node %0d, expected %0d", visited_node_i, want.node));
    if (last_i !== want.last)
      report_mismatch($sformatf("last %0b, expected %0b (node %0d)", last_i, want.last,
                                want.node));
    if (error_i !== want.err)
      report_mismatch($sformatf("error %0d, expected %0d (node %0d)", error_i, want.err,
                                want.node));
    if (edges_considered_i !== want.count)
      report_mismatch($sformatf("edges_considered %0d, expected %0d (node %0d)",
                                edges_considered_i, want.count, want.node));
  endtask

  // Outputs are checked before the input of the same edge is predicted, so a
  // result can never be matched against an item accepted on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) check_visit();
      if (in_valid_i && in_ready_i) predict_item(op_e'(op_i), node_a_i, node_b_i);
      n_pending = expected_visits.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the traversal engine testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bfs_pkg::*;

  localparam int Nodes = 64;
  localparam int Edges = 256;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [OpW-1:0]    op_i = OpAddNode;
  logic [NodeW-1:0]  node_a_i = '0;
  logic [NodeW-1:0]  node_b_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [NodeW-1:0]  visited_node_o;
  logic              last_o;
  logic [ErrW-1:0]   error_o;
  logic [CountW-1:0] edges_considered_o;

  int chk_fails;
  int chk_pending;

  int beats_sent = 0;
  bit calm = 1'b0;
  int hold_reqs = 0;
  int holds_served = 0;
  bit holding = 1'b0;
  int win_base = 0;
  int win_span = 63;

  bfs_traversal_engine_core #(
    .MAX_NODES(Nodes),
    .MAX_EDGES(Edges)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .node_a_i,
    .node_b_i,
    .out_valid_o,
    .out_ready_i,
    .visited_node_o,
    .last_o,
    .error_o,
    .edges_considered_o
  );

  bfs_traversal_engine_core_checker #(
    .MAX_NODES(Nodes),
    .MAX_EDGES(Edges)
  ) u_chk (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i(in_ready_o),
    .op_i,
    .node_a_i,
    .node_b_i,
    .out_valid_i(out_valid_o),
    .out_ready_i,
    .visited_node_i(visited_node_o),
    .last_i(last_o),
    .error_i(error_o),
    .edges_considered_i(edges_considered_o),
    .fail_count_o(chk_fails),
    .pending_o(chk_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #400ms;
    $display("bfs_traversal_engine_core verification failed");
    $finish;
  end

  function automatic logic [NodeW-1:0] rnd_node();
    return NodeW'($urandom_range(0, Nodes - 1));
  endfunction

  // Node drawn from the current window, so that loads and runs hit a connected patch.
  function automatic logic [NodeW-1:0] pick_node();
    return NodeW'((win_base + $urandom_range(0, win_span)) % Nodes);
  endfunction

  // Offers one beat, with a random gap in front of it unless the run is calm.
  task automatic send_beat(input op_e op, input logic [NodeW-1:0] a,
                           input logic [NodeW-1:0] b);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    node_a_i   <= a;
    node_b_i   <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  // Mostly load-then-run sequences on a small window, with clears and noise mixed in.
  task automatic random_part(input int n_items, input int calm_tail);
    int target;
    int r;
    int k;
    int m;
    target = beats_sent + n_items;
    while (beats_sent < target) begin
      calm = (target - beats_sent <= calm_tail);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_beat(OpClear, rnd_node(), rnd_node());
      end else if (r < 14) begin
        send_beat(op_e'($urandom_range(0, 3)), rnd_node(), rnd_node());
      end else begin
        win_base = $urandom_range(0, Nodes - 1);
        win_span = ($urandom_range(0, 11) == 0) ? Nodes - 1 : $urandom_range(1, 10);
        k = $urandom_range(1, 10);
        repeat (k) begin
          if ($urandom_range(0, 5) == 0) send_beat(OpAddNode, pick_node(), rnd_node());
          else send_beat(OpAddEdge, pick_node(), pick_node());
        end
        m = $urandom_range(1, 2);
        repeat (m) begin
          send_beat(OpRun, ($urandom_range(0, 9) == 0) ? rnd_node() : pick_node(), rnd_node());
        end
      end
    end
  endtask

  // Receiver: random ready bursts, a long counted hold-off on request, steady when calm.
  initial begin
    int len;
    @(posedge clk_i);
    forever begin
      if (hold_reqs != holds_served) begin
        out_ready_i <= 1'b0;
        holding = 1'b1;
        repeat (300) @(posedge clk_i);
        holding = 1'b0;
        holds_served++;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b1;
        len = $urandom_range(1, 40);
        repeat (len) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        len = $urandom_range(1, 19);
        repeat (len) @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty graph, isolated nodes, self loop, duplicates, clear.
    send_beat(OpRun, 6'd0, 6'd63);
    send_beat(OpAddNode, 6'd63, 6'd0);
    send_beat(OpRun, 6'd63, 6'd0);
    send_beat(OpAddEdge, 6'd0, 6'd63);
    send_beat(OpAddEdge, 6'd63, 6'd0);
    send_beat(OpAddEdge, 6'd0, 6'd0);
    send_beat(OpAddEdge, 6'd0, 6'd63);
    send_beat(OpAddEdge, 6'd63, 6'd42);
    send_beat(OpRun, 6'd0, 6'd21);
    send_beat(OpRun, 6'd42, 6'd0);
    send_beat(OpRun, 6'd21, 6'd42);
    send_beat(OpAddNode, 6'd21, 6'd63);
    send_beat(OpRun, 6'd21, 6'd63);
    send_beat(OpClear, 6'd42, 6'd21);
    send_beat(OpRun, 6'd63, 6'd0);
    send_beat(OpAddNode, 6'd0, 6'd63);
    send_beat(OpAddEdge, 6'd1, 6'd2);
    send_beat(OpAddEdge, 6'd2, 6'd3);
    send_beat(OpAddEdge, 6'd3, 6'd1);
    send_beat(OpAddEdge, 6'd1, 6'd3);
    send_beat(OpRun, 6'd1, 6'd63);
    send_beat(OpRun, 6'd0, 6'd63);
    send_beat(OpRun, 6'd3, 6'd0);

    random_part(60, 0);

    // Hold the receiver off across a run while more beats queue up behind it.
    win_base = $urandom_range(0, Nodes - 1);
    win_span = 15;
    repeat (14) send_beat(OpAddEdge, pick_node(), pick_node());
    hold_reqs++;
    while (!holding) @(posedge clk_i);
    send_beat(OpRun, pick_node(), rnd_node());
    send_beat(OpAddNode, pick_node(), rnd_node());
    send_beat(OpRun, pick_node(), rnd_node());
    send_beat(OpAddEdge, pick_node(), pick_node());

    // Sender pause until every result is back.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);

    // Fill the edge store, then push past it; node 63 stays out of the fill.
    send_beat(OpClear, rnd_node(), rnd_node());
    send_beat(OpAddNode, 6'd0, rnd_node());
    repeat (Edges) send_beat(OpAddEdge, NodeW'($urandom_range(0, Nodes - 2)),
                             NodeW'($urandom_range(0, Nodes - 2)));
    send_beat(OpAddEdge, 6'd63, 6'd63);
    send_beat(OpAddEdge, 6'd63, 6'd0);
    send_beat(OpRun, 6'd63, rnd_node());
    send_beat(OpRun, 6'd0, rnd_node());
    send_beat(OpAddNode, 6'd63, rnd_node());
    send_beat(OpRun, 6'd63, rnd_node());
    send_beat(OpClear, rnd_node(), rnd_node());
    send_beat(OpAddEdge, 6'd5, 6'd9);
    send_beat(OpRun, 6'd5, rnd_node());

    random_part(50, 30);

    in_valid_i <= 1'b0;
    calm = 1'b1;
    @(posedge clk_i);
    while (chk_pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("bfs_traversal_engine_core verification clean");
    end else begin
      $display("bfs_traversal_engine_core verification failed");
    end
    $finish;
  end

endmodule
